// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, masked while reset is active
`define ASSERT_RST(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// property checked at every rising edge, reset included
`define ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

// File: rtl/acs_pkg.sv
// ---------------------------------------------------------------------------
// acs_pkg
// shared types and codes of the adc conversion sequencer
// ---------------------------------------------------------------------------
package acs_pkg;

  // input actions
  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_ENABLE  = 3'd1;
  localparam logic [2:0] ACT_DISABLE = 3'd2;
  localparam logic [2:0] ACT_START   = 3'd3;
  localparam logic [2:0] ACT_CLEAR   = 3'd4;

  // window compare modes
  localparam logic [2:0] WIN_NONE    = 3'd0;
  localparam logic [2:0] WIN_BELOW   = 3'd1;
  localparam logic [2:0] WIN_ABOVE   = 3'd2;
  localparam logic [2:0] WIN_INSIDE  = 3'd3;
  localparam logic [2:0] WIN_OUTSIDE = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_ACCUM_LOG2    = 3'd0;
  localparam logic [2:0] REG_LOW_RES       = 3'd1;
  localparam logic [2:0] REG_WINDOW_MODE   = 3'd2;
  localparam logic [2:0] REG_WIN_LOW       = 3'd3;
  localparam logic [2:0] REG_WIN_HIGH      = 3'd4;
  localparam logic [2:0] REG_FREE_RUN      = 3'd5;
  localparam logic [2:0] REG_SAMPLE_DELAY  = 3'd6;
  localparam logic [2:0] REG_SAMPLE_LENGTH = 3'd7;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 16;

  // timing constants
  localparam logic [2:0] MAX_ACCUM_LOG2 = 3'd6;
  localparam logic [5:0] DELAY_BASE     = 6'd2;
  localparam logic [5:0] CONVERT_BASE   = 6'd11;

  typedef struct packed {
    logic [2:0]  action;
    logic [9:0]  sample;
    logic [1:0]  clear_mask;
  } in_item_t;

  typedef struct packed {
    logic        busy_res;
    logic [15:0] result;
    logic        ready_flag;
    logic        window_flag;
    logic        done_res;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  accum_log2;
    logic        low_res;
    logic [2:0]  window_mode;
    logic [15:0] win_low;
    logic [15:0] win_high;
    logic        free_run;
    logic [3:0]  sample_delay;
    logic [4:0]  sample_length;
  } cfg_t;

endpackage

// File: rtl/adc_conversion_sequencer.sv
// ---------------------------------------------------------------------------
// adc_conversion_sequencer
// adc conversion control: tick-driven sample sequencing, accumulation,
// result latch and window compare with interrupt flags
// ---------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------
//  in      | input     | in_valid_i/in_stall_o | in_data_i  (in_item_t)
//  out     | output    | out_valid_o/out_stall_i| out_data_o (out_item_t)
//  cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// one item per clock cycle while the output is not stalled, set by the
// combinational state update between the input and result registers
// an item is held in the input register, its result in the result register
// reset clears the state machine, flags, result and all configuration
// a stalled output holds its result; the input register still fills once,
// and in_stall_o rises only when both registers are full
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module adc_conversion_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  acs_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output acs_pkg::out_item_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [acs_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [acs_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic               in_valid_q;
  acs_pkg::in_item_t  in_data_q;
  logic               out_valid_q;
  acs_pkg::out_item_t out_data_q;
  acs_pkg::out_item_t res;
  acs_pkg::cfg_t      cfg;
  logic               advance;
  logic               in_load;

  // pipeline control
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_load    = !in_valid_q || advance;
  assign in_stall_o = !in_load;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  acs_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) begin
      in_data_q <= in_data_i;
    end
  end

  // state update
  acs_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (in_data_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // checks
  `ASSERT_RST(a_done_sets_ready, clk_i, rst_ni,
              out_valid_q && out_data_q.done_res |-> out_data_q.ready_flag)
  `ASSERT_RST(a_done_idle_no_free_run, clk_i, rst_ni,
              out_valid_q && out_data_q.done_res && !cfg.free_run |-> !out_data_q.busy_res)
  `ASSERT_ALWAYS(a_stall_only_when_full, clk_i,
                 in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
  `ASSERT_RST(a_result_from_input_reg, clk_i, rst_ni, $rose(out_valid_q) |-> $past(in_valid_q))

endmodule

// File: rtl/acs_cfg.sv
// ---------------------------------------------------------------------------
// acs_cfg
// configuration register file written through the config channel
// ---------------------------------------------------------------------------
module acs_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             wr_en_i,
  input  logic [acs_pkg::CfgIndexW-1:0]    wr_index_i,
  input  logic [acs_pkg::CfgDataW-1:0]     wr_data_i,
  output acs_pkg::cfg_t                    cfg_o
);

  acs_pkg::cfg_t cfg_q;

  // register writes, one register per transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en_i) begin
      case (wr_index_i)
        acs_pkg::REG_ACCUM_LOG2:    cfg_q.accum_log2    <= wr_data_i[2:0];
        acs_pkg::REG_LOW_RES:       cfg_q.low_res       <= wr_data_i[0];
        acs_pkg::REG_WINDOW_MODE:   cfg_q.window_mode   <= wr_data_i[2:0];
        acs_pkg::REG_WIN_LOW:       cfg_q.win_low       <= wr_data_i[15:0];
        acs_pkg::REG_WIN_HIGH:      cfg_q.win_high      <= wr_data_i[15:0];
        acs_pkg::REG_FREE_RUN:      cfg_q.free_run      <= wr_data_i[0];
        acs_pkg::REG_SAMPLE_DELAY:  cfg_q.sample_delay  <= wr_data_i[3:0];
        acs_pkg::REG_SAMPLE_LENGTH: cfg_q.sample_length <= wr_data_i[4:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/acs_core.sv
// ---------------------------------------------------------------------------
// acs_core
// conversion state machine, accumulator, result and interrupt flags
// ---------------------------------------------------------------------------
module acs_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  acs_pkg::in_item_t  item_i,
  input  acs_pkg::cfg_t      cfg_i,
  output acs_pkg::out_item_t res_o
);

  typedef enum logic [2:0] {
    PH_DISABLED,
    PH_IDLE,
    PH_START,
    PH_DELAY,
    PH_CONVERT
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [5:0]  countdown_q, countdown_d;
  logic [6:0]  sample_count_q, sample_count_d;
  logic [15:0] accum_q, accum_d;
  logic [15:0] result_q, result_d;
  logic        ready_q, ready_d;
  logic        window_q, window_d;
  logic        done;

  logic [5:0]  cd_dec;
  logic [6:0]  sc_inc;
  logic [2:0]  n_eff;
  logic [6:0]  sample_limit;
  logic [9:0]  code;
  logic [5:0]  delay_load;
  logic [5:0]  convert_load;
  logic        win_hit;

  // per-tick helpers
  assign cd_dec       = (countdown_q != '0) ? countdown_q - 6'd1 : '0;
  assign sc_inc       = sample_count_q + 7'd1;
  assign n_eff        = (cfg_i.accum_log2 > acs_pkg::MAX_ACCUM_LOG2) ?
                        acs_pkg::MAX_ACCUM_LOG2 : cfg_i.accum_log2;
  assign sample_limit = 7'd1 << n_eff;
  assign code         = cfg_i.low_res ? {2'b00, item_i.sample[9:2]} : item_i.sample;
  assign delay_load   = acs_pkg::DELAY_BASE + {2'b00, cfg_i.sample_delay};
  assign convert_load = acs_pkg::CONVERT_BASE + {1'b0, cfg_i.sample_length};

  // window compare on the sum about to be latched
  always_comb begin
    case (cfg_i.window_mode)
      acs_pkg::WIN_BELOW:   win_hit = accum_q < cfg_i.win_low;
      acs_pkg::WIN_ABOVE:   win_hit = accum_q > cfg_i.win_high;
      acs_pkg::WIN_INSIDE:  win_hit = (accum_q > cfg_i.win_low) &&
                                      (accum_q < cfg_i.win_high);
      acs_pkg::WIN_OUTSIDE: win_hit = (accum_q < cfg_i.win_low) ||
                                      (accum_q > cfg_i.win_high);
      default:              win_hit = 1'b0;
    endcase
  end

  // next state for one item
  always_comb begin
    phase_d        = phase_q;
    countdown_d    = countdown_q;
    sample_count_d = sample_count_q;
    accum_d        = accum_q;
    result_d       = result_q;
    ready_d        = ready_q;
    window_d       = window_q;
    done           = 1'b0;

    case (item_i.action)
      acs_pkg::ACT_TICK: begin
        if (phase_q inside {PH_START, PH_DELAY, PH_CONVERT}) begin
          countdown_d = cd_dec;
          if (cd_dec == '0) begin
            case (phase_q)
              PH_START: begin
                phase_d     = PH_DELAY;
                countdown_d = delay_load;
              end
              PH_DELAY: begin
                accum_d     = (sample_count_q == '0) ? {6'd0, code} :
                              accum_q + {6'd0, code};
                phase_d     = PH_CONVERT;
                countdown_d = convert_load;
              end
              PH_CONVERT: begin
                sample_count_d = sc_inc;
                if (sc_inc < sample_limit) begin
                  phase_d     = PH_DELAY;
                  countdown_d = delay_load;
                end else begin
                  result_d = accum_q;
                  phase_d  = PH_IDLE;
                  ready_d  = 1'b1;
                  done     = 1'b1;
                  if (win_hit) begin
                    window_d = 1'b1;
                  end
                  if (cfg_i.free_run) begin
                    phase_d        = PH_START;
                    countdown_d    = 6'd1;
                    sample_count_d = '0;
                  end
                end
              end
              default: ;
            endcase
          end
        end
      end
      acs_pkg::ACT_ENABLE: begin
        if (phase_q == PH_DISABLED) begin
          phase_d = PH_IDLE;
        end
      end
      acs_pkg::ACT_DISABLE: begin
        if (phase_q != PH_DISABLED) begin
          phase_d     = PH_DISABLED;
          countdown_d = '0;
        end
      end
      acs_pkg::ACT_START: begin
        if (phase_q == PH_IDLE) begin
          phase_d        = PH_START;
          countdown_d    = 6'd1;
          sample_count_d = '0;
        end
      end
      acs_pkg::ACT_CLEAR: begin
        if (item_i.clear_mask[0]) begin
          ready_d = 1'b0;
        end
        if (item_i.clear_mask[1]) begin
          window_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // state registers, advanced once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_DISABLED;
      countdown_q    <= '0;
      sample_count_q <= '0;
      accum_q        <= '0;
      result_q       <= '0;
      ready_q        <= 1'b0;
      window_q       <= 1'b0;
    end else if (en_i) begin
      phase_q        <= phase_d;
      countdown_q    <= countdown_d;
      sample_count_q <= sample_count_d;
      accum_q        <= accum_d;
      result_q       <= result_d;
      ready_q        <= ready_d;
      window_q       <= window_d;
    end
  end

  // result item seen after this item
  assign res_o.busy_res    = (phase_d != PH_DISABLED) && (phase_d != PH_IDLE);
  assign res_o.result      = result_d;
  assign res_o.ready_flag  = ready_d;
  assign res_o.window_flag = window_d;
  assign res_o.done_res    = done;

endmodule
